/* hw/rtl/bounded_deque_with_search_top_macros.svh */
// Assertion macros for the deque checker.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define BDQ_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define BDQ_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* hw/rtl/bdq_pkg.sv */
`default_nettype none

package bdq_pkg;

   localparam int WORD_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CONTAINS   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd5;
   localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic load;          // latch request word
      logic exec_op;       // push / pop effect
      logic walk_init;     // search pointer to front
      logic walk;          // issue read at walk pointer
      logic shift_init;    // walk pointer behind the match
      logic shift_write;   // write pending word one place forward
      logic set_found;
      logic remove_done;   // drop one entry after closing the gap
      logic rd_front;
      logic rd_back;
      logic finish;        // present result
   } ctl_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              is_zero;
      logic              hit;
      logic              walk_done;
   } dp_status_type;

endpackage

`default_nettype wire

/* hw/rtl/bdq_ctrl.sv */
`default_nettype none

module bdq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire bdq_pkg::dp_status_type st,
   output bdq_pkg::ctl_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_RDF   = 3'd4;
   localparam logic [2:0] S_RDB   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec_op = 1'b1;
            if ((st.kind == bdq_pkg::KIND_CONTAINS || st.kind == bdq_pkg::KIND_REMOVE)
                && !st.is_zero) begin
               cmd.walk_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               state_in = S_RDF;
            end
         end
         S_SCAN: begin
            if (st.hit) begin
               cmd.set_found = 1'b1;
               if (st.kind == bdq_pkg::KIND_REMOVE) begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT;
               end else begin
                  state_in = S_RDF;
               end
            end else if (st.walk_done) begin
               state_in = S_RDF;
            end else begin
               cmd.walk = 1'b1;
            end
         end
         S_SHIFT: begin
            if (st.walk_done) begin
               cmd.remove_done = 1'b1;
               state_in        = S_RDF;
            end else begin
               cmd.walk        = 1'b1;
               cmd.shift_write = 1'b1;
            end
         end
         S_RDF: begin
            if (st.is_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_front = 1'b1;
               state_in     = S_RDB;
            end
         end
         S_RDB: begin
            cmd.rd_back = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/bdq_datapath.sv */
`default_nettype none

module bdq_datapath #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bdq_pkg::ctl_cmd_type                  cmd,
   output bdq_pkg::dp_status_type                     st,
   input  wire logic        [bdq_pkg::KIND_W-1:0]     req_kind,
   input  wire logic signed [bdq_pkg::WORD_W-1:0]     req_item_value,
   output logic                                       rsp_valid,
   output logic             [bdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                       rsp_found,
   output logic signed      [bdq_pkg::WORD_W-1:0]     rsp_front_word,
   output logic signed      [bdq_pkg::WORD_W-1:0]     rsp_back_word,
   output logic                                       rsp_is_empty,
   output logic             [$clog2(DEPTH+1)-1:0]     rsp_entry_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (VALUE_WIDTH < bdq_pkg::WORD_W) ? VALUE_WIDTH : bdq_pkg::WORD_W;

   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
      logic [IW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IW+1)'(DEPTH)) begin
         sum = sum - (IW+1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   logic [SW-1:0] mem [DEPTH];

   logic [IW-1:0]                  head_ff, head_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [bdq_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [SW-1:0]                  value_ff, value_in;
   logic [bdq_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           found_ff, found_in;
   logic [CW-1:0]                  pos_ff, pos_in;
   logic                           pend_ff, pend_in;
   logic [CW-1:0]                  ppos_ff, ppos_in;
   logic [SW-1:0]                  front_ff, front_in;
   logic [SW-1:0]                  rd_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bdq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [SW-1:0]                  rsp_front_ff, rsp_front_in;
   logic [SW-1:0]                  rsp_back_ff, rsp_back_in;
   logic                           rsp_empty_ff, rsp_empty_in;
   logic [CW-1:0]                  rsp_count_ff, rsp_count_in;

   logic                           wr_en;
   logic [IW-1:0]                  wr_addr;
   logic [SW-1:0]                  wr_data;
   logic [IW-1:0]                  rd_addr;

   logic                           is_zero;
   logic                           is_full;
   logic [IW-1:0]                  head_dec;
   logic [CW-1:0]                  cnt_m1;
   logic [CW-1:0]                  ppos_m1;
   logic                           issue;

   assign is_zero  = (count_ff == '0);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign head_dec = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - IW'(1);
   assign cnt_m1   = count_ff - CW'(1);
   assign ppos_m1  = ppos_ff - CW'(1);
   assign issue    = (pos_ff < count_ff);

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      ppos_in       = ppos_ff;
      front_in      = front_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_of(head_ff, ppos_m1[IW-1:0]);
      wr_data       = rd_data_ff;
      rd_addr       = slot_of(head_ff, pos_ff[IW-1:0]);

      if (cmd.load) begin
         kind_in   = req_kind;
         value_in  = req_item_value[SW-1:0];
         status_in = bdq_pkg::ST_OK;
         found_in  = 1'b0;
      end

      if (cmd.exec_op) begin
         unique case (kind_ff)
            bdq_pkg::KIND_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = bdq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  wr_data  = value_ff;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
               end
            end
            bdq_pkg::KIND_PUSH_BACK: begin
               if (is_full) begin
                  status_in = bdq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = slot_of(head_ff, count_ff[IW-1:0]);
                  wr_data  = value_ff;
                  count_in = count_ff + CW'(1);
               end
            end
            bdq_pkg::KIND_POP_FRONT: begin
               if (is_zero) begin
                  status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  head_in  = slot_of(head_ff, IW'(1));
                  count_in = cnt_m1;
               end
            end
            bdq_pkg::KIND_POP_BACK: begin
               if (is_zero) begin
                  status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  count_in = cnt_m1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.walk_init) begin
         pos_in  = '0;
         pend_in = 1'b0;
      end

      if (cmd.walk) begin
         pend_in = issue;
         ppos_in = pos_ff;
         if (issue) begin
            pos_in = pos_ff + CW'(1);
         end
      end

      if (cmd.shift_init) begin
         pos_in  = ppos_ff + CW'(1);
         pend_in = 1'b0;
      end

      // gap closing: word read last cycle moves one place towards the front
      if (cmd.shift_write && pend_ff) begin
         wr_en = 1'b1;
      end

      if (cmd.set_found) begin
         found_in = 1'b1;
      end

      if (cmd.remove_done) begin
         count_in = cnt_m1;
      end

      if (cmd.rd_front) begin
         rd_addr = head_ff;
      end

      if (cmd.rd_back) begin
         rd_addr  = slot_of(head_ff, cnt_m1[IW-1:0]);
         front_in = rd_data_ff;
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_found_in  = found_ff;
         rsp_front_in  = is_zero ? '0 : front_ff;
         rsp_back_in   = is_zero ? '0 : rd_data_ff;
         rsp_empty_in  = is_zero;
         rsp_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      ppos_ff       <= ppos_in;
      front_ff      <= front_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign st.kind      = kind_ff;
   assign st.is_zero   = is_zero;
   assign st.hit       = pend_ff && (rd_data_ff == value_ff);
   assign st.walk_done = !pend_ff && !issue;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_front_word  = bdq_pkg::WORD_W'(rsp_front_ff);
   assign rsp_back_word   = bdq_pkg::WORD_W'(rsp_back_ff);
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

/* hw/rtl/bounded_deque_with_search_top.sv */
// channel  | ports                                        | transfer
// ---------+----------------------------------------------+----------------------------
// request  | start, busy, req_kind, req_item_value        | start high while busy low
// response | rsp_valid, rsp_status, rsp_found, rsp_front_ | rsp_valid high, one cycle
//          | word, rsp_back_word, rsp_is_empty,           |
//          | rsp_entry_count                              |
//
// Push, pop, query: busy in EXEC, RDF, RDB, FIN (no RDB if left empty); result next cycle.
// Contains and remove walk the entries through the single read port of the store:
// the search runs in SCAN, a remove that hits closes the gap in SHIFT, and both
// then finish through RDF, RDB and FIN like the other words.
// Synchronous reset empties the deque; the store itself is not cleared.
// The receiver cannot stall; a new word may be started as a result is shown.
`default_nettype none

module bounded_deque_with_search_top #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic        [bdq_pkg::KIND_W-1:0]     req_kind,
   input  wire logic signed [bdq_pkg::WORD_W-1:0]     req_item_value,
   output logic                                       rsp_valid,
   output logic             [bdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                       rsp_found,
   output logic signed      [bdq_pkg::WORD_W-1:0]     rsp_front_word,
   output logic signed      [bdq_pkg::WORD_W-1:0]     rsp_back_word,
   output logic                                       rsp_is_empty,
   output logic             [$clog2(DEPTH+1)-1:0]     rsp_entry_count
);

   bdq_pkg::ctl_cmd_type   cmd;
   bdq_pkg::dp_status_type st;

   bdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   bdq_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_kind        (req_kind),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_front_word  (rsp_front_word),
      .rsp_back_word   (rsp_back_word),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

`default_nettype wire

/* hw/rtl/bdq_checker.sv */
`default_nettype none

`include "bounded_deque_with_search_top_macros.svh"

module bdq_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_valid,
   input wire logic        [bdq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic                                rsp_found,
   input wire logic signed [bdq_pkg::WORD_W-1:0]   rsp_front_word,
   input wire logic signed [bdq_pkg::WORD_W-1:0]   rsp_back_word,
   input wire logic                                rsp_is_empty,
   input wire logic        [$clog2(DEPTH+1)-1:0]   rsp_entry_count
);

   `BDQ_ASSERT_ANY(a_reset_idle, reset |=> !busy && !rsp_valid, "not idle after reset")
   `BDQ_ASSERT_CLK(a_start_busy, start && !busy |=> busy && !rsp_valid, "word not taken")
   `BDQ_ASSERT_CLK(a_empty_words, rsp_valid && rsp_is_empty |-> rsp_front_word == 0 && rsp_back_word == 0 && rsp_entry_count == 0, "empty result not clean")
   `BDQ_ASSERT_CLK(a_refused_no_hit, rsp_valid && rsp_status != bdq_pkg::ST_OK |-> !rsp_found, "refused word reports a hit")

endmodule

bind bounded_deque_with_search_top bdq_checker #(
   .DEPTH (DEPTH)
) u_bdq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found       (rsp_found),
   .rsp_front_word  (rsp_front_word),
   .rsp_back_word   (rsp_back_word),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_entry_count (rsp_entry_count)
);

`default_nettype wire

/* bench/bounded_deque_with_search_top_tb.sv */
`default_nettype none

module bounded_deque_with_search_top_tb;

   localparam int DEPTH          = 16;
   localparam int CNT_W          = $clog2(DEPTH + 1);
   localparam int RANDOM_WORDS   = 1730;
   localparam int PHASE_LEN      = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 2 * DEPTH + 16;
   localparam logic [bdq_pkg::KIND_W-1:0] KIND_SPARE = 3'd7;

   typedef struct packed {
      logic [bdq_pkg::STATUS_W-1:0]      status;
      logic                              found;
      logic signed [bdq_pkg::WORD_W-1:0] front_word;
      logic signed [bdq_pkg::WORD_W-1:0] back_word;
      logic                              is_empty;
      logic [CNT_W-1:0]                  entry_count;
   } deque_result_type;

   class deque_scoreboard;
      logic signed [bdq_pkg::WORD_W-1:0] slot [DEPTH];
      int head;
      int fill;
      deque_result_type outstanding [$];
      int failures;

      function new();
         head = 0;
         fill = 0;
         failures = 0;
      endfunction

      function int locate(logic signed [bdq_pkg::WORD_W-1:0] v);
         int k;
         for (k = 0; k < fill; k++) begin
            if (slot[(head + k) % DEPTH] == v) return k;
         end
         return -1;
      endfunction

      // model the queue for one accepted word and log the result it must give
      function void note_word(logic [bdq_pkg::KIND_W-1:0] kind,
                              logic signed [bdq_pkg::WORD_W-1:0] v);
         deque_result_type r;
         int pos;
         int k;
         r.status = bdq_pkg::ST_OK;
         r.found  = 1'b0;
         case (kind)
            bdq_pkg::KIND_PUSH_FRONT: begin
               if (fill == DEPTH) begin
                  r.status = bdq_pkg::ST_FULL;
               end else begin
                  head = (head + DEPTH - 1) % DEPTH;
                  slot[head] = v;
                  fill++;
               end
            end
            bdq_pkg::KIND_PUSH_BACK: begin
               if (fill == DEPTH) begin
                  r.status = bdq_pkg::ST_FULL;
               end else begin
                  slot[(head + fill) % DEPTH] = v;
                  fill++;
               end
            end
            bdq_pkg::KIND_POP_FRONT: begin
               if (fill == 0) begin
                  r.status = bdq_pkg::ST_EMPTY;
               end else begin
                  head = (head + 1) % DEPTH;
                  fill--;
               end
            end
            bdq_pkg::KIND_POP_BACK: begin
               if (fill == 0) r.status = bdq_pkg::ST_EMPTY;
               else fill--;
            end
            bdq_pkg::KIND_CONTAINS: begin
               r.found = (locate(v) >= 0);
            end
            bdq_pkg::KIND_REMOVE: begin
               pos = locate(v);
               if (pos >= 0) begin
                  r.found = 1'b1;
                  for (k = pos; k + 1 < fill; k++)
                     slot[(head + k) % DEPTH] = slot[(head + k + 1) % DEPTH];
                  fill--;
               end
            end
            default: begin
            end
         endcase
         if (fill == 0) begin
            r.front_word = '0;
            r.back_word  = '0;
         end else begin
            r.front_word = slot[head];
            r.back_word  = slot[(head + fill - 1) % DEPTH];
         end
         r.is_empty    = (fill == 0);
         r.entry_count = CNT_W'(fill);
         outstanding.push_back(r);
      endfunction

      function int pending();
         return outstanding.size();
      endfunction

      function void check_word(deque_result_type got);
         deque_result_type want;
         if (outstanding.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display({"result with no word outstanding: ",
                         "st=%0d f=%0d front=%0d back=%0d e=%0d n=%0d"},
                        got.status, got.found, got.front_word, got.back_word,
                        got.is_empty, got.entry_count);
            return;
         end
         want = outstanding.pop_front();
         if (got.status !== want.status || got.found !== want.found ||
             got.front_word !== want.front_word || got.back_word !== want.back_word ||
             got.is_empty !== want.is_empty || got.entry_count !== want.entry_count) begin
            failures++;
            if (failures <= 10) begin
               $display("wrong result: expected st=%0d f=%0d front=%0d back=%0d e=%0d n=%0d",
                        want.status, want.found, want.front_word, want.back_word,
                        want.is_empty, want.entry_count);
               $display("              actual   st=%0d f=%0d front=%0d back=%0d e=%0d n=%0d",
                        got.status, got.found, got.front_word, got.back_word,
                        got.is_empty, got.entry_count);
            end
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [bdq_pkg::KIND_W-1:0]        req_kind;
   logic signed [bdq_pkg::WORD_W-1:0] req_item_value;
   logic                              rsp_valid;
   logic [bdq_pkg::STATUS_W-1:0]      rsp_status;
   logic                              rsp_found;
   logic signed [bdq_pkg::WORD_W-1:0] rsp_front_word;
   logic signed [bdq_pkg::WORD_W-1:0] rsp_back_word;
   logic                              rsp_is_empty;
   logic [CNT_W-1:0]                  rsp_entry_count;

   deque_scoreboard sb;
   int idle_cycles;

   bounded_deque_with_search_top #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (bdq_pkg::WORD_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_front_word  (rsp_front_word),
      .rsp_back_word   (rsp_back_word),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid)
            sb.check_word(deque_result_type'{rsp_status, rsp_found, rsp_front_word,
                                             rsp_back_word, rsp_is_empty, rsp_entry_count});
         if (start && !busy) sb.note_word(req_kind, req_item_value);
         if (rsp_valid || (start && !busy)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_deque_with_search_top: mismatch");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // start stays high across back-to-back words; only lowered ahead of a gap
   task automatic send_word(input logic [bdq_pkg::KIND_W-1:0] kind,
                            input logic signed [bdq_pkg::WORD_W-1:0] value, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_item_value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [bdq_pkg::WORD_W-1:0] pick_value();
      int r;
      logic signed [bdq_pkg::WORD_W-1:0] extremes [4];
      extremes = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sh1};
      r = $urandom_range(0, 9);
      if (r < 5) return $signed(bdq_pkg::WORD_W'($urandom_range(0, 7))) - 4;
      if (r == 5) return extremes[$urandom_range(0, 3)];
      return $signed($urandom);
   endfunction

   // mode 0 fills, 1 drains, 2 searches, 3 mixes
   function automatic logic [bdq_pkg::KIND_W-1:0] pick_kind(int mode);
      int w [8];
      int r;
      int k;
      logic [bdq_pkg::KIND_W-1:0] kinds [8];
      kinds = '{bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK,
                bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK,
                bdq_pkg::KIND_CONTAINS, bdq_pkg::KIND_REMOVE,
                bdq_pkg::KIND_QUERY, KIND_SPARE};
      case (mode)
         0:       w = '{40, 40, 4, 4, 5, 4, 2, 1};
         1:       w = '{8, 8, 28, 28, 6, 18, 3, 1};
         2:       w = '{14, 14, 6, 6, 30, 26, 3, 1};
         default: w = '{15, 15, 14, 14, 15, 15, 6, 6};
      endcase
      r = $urandom_range(0, 99);
      for (k = 0; k < 7; k++) begin
         if (r < w[k]) return kinds[k];
         r -= w[k];
      end
      return kinds[7];
   endfunction

   initial begin
      int mode;
      bit quiet;
      int n;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_kind       <= bdq_pkg::KIND_QUERY;
      req_item_value <= '0;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: refusals, searches and the spare code
      send_word(bdq_pkg::KIND_QUERY, 0, 0);
      send_word(bdq_pkg::KIND_POP_FRONT, 0, 1);
      send_word(bdq_pkg::KIND_POP_BACK, 0, 0);
      send_word(bdq_pkg::KIND_CONTAINS, 0, 2);
      send_word(bdq_pkg::KIND_REMOVE, 0, 0);
      send_word(KIND_SPARE, 32'sh7fffffff, 0);
      // extremes at both ends, then searches, removes and pops
      send_word(bdq_pkg::KIND_PUSH_FRONT, 32'sh7fffffff, 0);
      send_word(bdq_pkg::KIND_PUSH_BACK, 32'sh80000000, 3);
      send_word(bdq_pkg::KIND_PUSH_FRONT, 0, 0);
      send_word(bdq_pkg::KIND_PUSH_BACK, -1, 0);
      send_word(bdq_pkg::KIND_CONTAINS, 32'sh80000000, 0);
      send_word(bdq_pkg::KIND_CONTAINS, 32'sh12345, 1);
      send_word(bdq_pkg::KIND_REMOVE, 32'sh7fffffff, 0);
      send_word(bdq_pkg::KIND_REMOVE, 5, 0);
      send_word(bdq_pkg::KIND_PUSH_FRONT, -1, 0);
      send_word(bdq_pkg::KIND_REMOVE, -1, 4);
      send_word(bdq_pkg::KIND_POP_BACK, 0, 0);
      send_word(bdq_pkg::KIND_POP_FRONT, 0, 0);
      send_word(bdq_pkg::KIND_QUERY, 0, 0);
      send_word(bdq_pkg::KIND_POP_BACK, 0, 0);
      drain_results();

      mode  = 0;
      quiet = 1'b0;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % PHASE_LEN == 0) begin
            if (n != 0 && $urandom_range(0, 3) == 0) drain_results();
            mode  = (n == 0) ? 0 : $urandom_range(0, 3);
            quiet = ($urandom_range(0, 3) == 0);
         end
         send_word(pick_kind(mode), pick_value(), pick_gap(quiet));
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("bounded_deque_with_search_top: match");
      end else begin
         $display("bounded_deque_with_search_top: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_datapath.sv
hw/rtl/bounded_deque_with_search_top.sv
hw/rtl/bdq_checker.sv
bench/bounded_deque_with_search_top_tb.sv
